@@ sv/plbp_pkg.sv @@
// plbp_pkg: types, constants and small arithmetic helpers of the point light
// blinn-phong shading core; used by plbp_pow and the top level
`default_nettype none

package plbp_pkg;

	// fixed-point formats
	localparam int FRAC    = 14;
	localparam int Q_W     = 15;
	localparam logic [Q_W-1:0] ONE_Q14 = 15'd16384;

	// square root and divider geometry
	localparam int SQ1_IW  = 34;                // sum of squares of light and view vectors
	localparam int SQ2_IW  = 32;                // sum of squares of the half vector
	localparam int ROOT_IW = 30;                // fractional power roots
	localparam int SQ1_LAT = (SQ1_IW + 1) / 2;
	localparam int SQ2_LAT = (SQ2_IW + 1) / 2;
	localparam int ROOT_LAT = (ROOT_IW + 1) / 2;
	localparam int DIV_NW  = 30;
	localparam int DIV_DW  = 17;
	localparam int DIV_QW  = 15;
	localparam int DIV_LAT = DIV_QW;
	localparam int POW_LAT = 4 * ROOT_LAT + 1;

	// configuration register indexes
	localparam logic [2:0] REG_LIGHT_X  = 3'd0;
	localparam logic [2:0] REG_LIGHT_Y  = 3'd1;
	localparam logic [2:0] REG_LIGHT_Z  = 3'd2;
	localparam logic [2:0] REG_DIFFUSE  = 3'd3;
	localparam logic [2:0] REG_SPECULAR = 3'd4;
	localparam logic [2:0] REG_AMBIENT  = 3'd5;

	typedef struct packed {
		logic signed [15:0] surface_x;
		logic signed [15:0] surface_y;
		logic signed [15:0] surface_z;
		logic signed [15:0] normal_x;
		logic signed [15:0] normal_y;
		logic signed [15:0] normal_z;
		logic signed [15:0] eye_x;
		logic signed [15:0] eye_y;
		logic signed [15:0] eye_z;
		logic [8:0]         visibility;
		logic [11:0]        shininess;
	} sample_t;

	typedef struct packed {
		logic       lit;
		logic [7:0] diffuse_r;
		logic [7:0] diffuse_g;
		logic [7:0] diffuse_b;
		logic [7:0] spec_r;
		logic [7:0] spec_g;
		logic [7:0] spec_b;
		logic [7:0] amb_r;
		logic [7:0] amb_g;
		logic [7:0] amb_b;
	} shade_t;

	// q1.14 product, operands at most 1.0
	function automatic logic [Q_W-1:0] qmul(logic [Q_W-1:0] a, logic [Q_W-1:0] c);
		logic [2*Q_W-1:0] prod;
		prod = {{Q_W{1'b0}}, a} * {{Q_W{1'b0}}, c};
		return prod[FRAC+Q_W-1:FRAC];
	endfunction

	// q2.28 dot product to a q1.14 intensity in [0, 1.0]
	function automatic logic [Q_W-1:0] clamp_q14(logic signed [31:0] d);
		logic [17:0] r;
		r = d[31:FRAC];
		if (d[31] || d == 32'sd0) begin
			return '0;
		end else if (r > 18'(ONE_Q14)) begin
			return ONE_Q14;
		end else begin
			return r[Q_W-1:0];
		end
	endfunction

	// color * intensity * visibility, scaled down by 2^22 and saturated
	function automatic logic [7:0] chan_sat(logic [31:0] prod);
		if (prod[31:30] != 2'b00) begin
			return 8'hff;
		end else begin
			return prod[29:22];
		end
	endfunction

endpackage

`default_nettype wire

@@ sv/plbp_delay.sv @@
// plbp_delay: enabled shift line that keeps side data aligned with the
// arithmetic stages; no package dependency
`default_nettype none

module plbp_delay #(
	parameter int W = 8,
	parameter int N = 1
) (
	input  wire logic         clk,
	input  wire logic         en,
	input  wire logic [W-1:0] d,
	output logic [W-1:0]      q
);

	logic [W-1:0] line_q [N];

	always_ff @(posedge clk) begin
		if (en) begin
			line_q[0] <= d;
			for (int i = 1; i < N; i++) begin
				line_q[i] <= line_q[i-1];
			end
		end
	end

	assign q = line_q[N-1];

endmodule

`default_nettype wire

@@ sv/plbp_sqrt.sv @@
// plbp_sqrt: pipelined integer square root, one result bit per stage,
// floor of the root; no package dependency
`default_nettype none

module plbp_sqrt #(
	parameter int IW = 34
) (
	input  wire logic                  clk,
	input  wire logic                  en,
	input  wire logic [IW-1:0]         x,
	output logic [(IW+1)/2-1:0]        root
);

	localparam int OW = (IW + 1) / 2;
	localparam int XW = 2 * OW;
	localparam int RW = OW + 3;

	logic [RW-1:0] rem_s  [OW];
	logic [OW-1:0] root_s [OW];
	logic [XW-1:0] x_s    [OW];

	for (genvar k = 0; k < OW; k++) begin : g_stage
		logic [RW-1:0] rem_in;
		logic [OW-1:0] root_in;
		logic [XW-1:0] x_in;
		logic [RW-1:0] cur;
		logic [RW-1:0] trial;
		logic          ge;

		if (k == 0) begin : g_first
			assign rem_in  = '0;
			assign root_in = '0;
			assign x_in    = XW'(x);
		end else begin : g_next
			assign rem_in  = rem_s[k-1];
			assign root_in = root_s[k-1];
			assign x_in    = x_s[k-1];
		end

		// bring down the next two radicand bits and try root*4+1
		assign cur   = {rem_in[RW-3:0], x_in[XW-1 -: 2]};
		assign trial = RW'({root_in, 2'b01});
		assign ge    = (cur >= trial);

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? (cur - trial) : cur;
				root_s[k] <= {root_in[OW-2:0], ge};
				x_s[k]    <= x_in << 2;
			end
		end
	end

	assign root = root_s[OW-1];

endmodule

`default_nettype wire

@@ sv/plbp_div.sv @@
// plbp_div: pipelined restoring divider, one quotient bit per stage; the
// quotient must fit in QW bits; no package dependency
`default_nettype none

module plbp_div #(
	parameter int NW = 30,
	parameter int DW = 17,
	parameter int QW = 15
) (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire logic [NW-1:0] num,
	input  wire logic [DW-1:0] den,
	output logic [QW-1:0]      quo
);

	logic [DW-1:0] rem_s [QW];
	logic [QW-1:0] nb_s  [QW];
	logic [DW-1:0] den_s [QW];
	logic [QW-1:0] quo_s [QW];

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic [DW-1:0] rem_in;
		logic [QW-1:0] nb_in;
		logic [DW-1:0] den_in;
		logic [QW-1:0] quo_in;
		logic [DW:0]   cur;
		logic [DW:0]   diff;
		logic          ge;

		if (k == 0) begin : g_first
			// upper numerator bits are below the divisor since the quotient fits
			assign rem_in = DW'(num[NW-1:QW]);
			assign nb_in  = num[QW-1:0];
			assign den_in = den;
			assign quo_in = '0;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign nb_in  = nb_s[k-1];
			assign den_in = den_s[k-1];
			assign quo_in = quo_s[k-1];
		end

		assign cur  = {rem_in, nb_in[QW-1]};
		assign diff = cur - {1'b0, den_in};
		assign ge   = (cur >= {1'b0, den_in});

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? diff[DW-1:0] : cur[DW-1:0];
				nb_s[k]  <= nb_in << 1;
				den_s[k] <= den_in;
				quo_s[k] <= {quo_in[QW-2:0], ge};
			end
		end
	end

	assign quo = quo_s[QW-1];

endmodule

`default_nettype wire

@@ sv/plbp_pow.sv @@
// plbp_pow: pipelined q1.14 power b^(s/16): squaring chain for the integer
// exponent bits, chained square roots for the fraction bits; uses plbp_pkg,
// plbp_sqrt and plbp_delay
`default_nettype none

module plbp_pow
	import plbp_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             en,
	input  wire logic [Q_W-1:0]   base,
	input  wire logic [11:0]      shin,
	output logic [Q_W-1:0]        pw
);

	localparam int QSTEPS = 8;

	// integer part: p *= q on a set bit, q = q*q
	logic [Q_W-1:0] pc_s [QSTEPS];
	logic [Q_W-1:0] qc_s [QSTEPS];
	logic [11:0]    sc_s [QSTEPS];

	for (genvar k = 0; k < QSTEPS; k++) begin : g_sq
		logic [Q_W-1:0] p_in;
		logic [Q_W-1:0] q_in;
		logic [11:0]    s_in;

		if (k == 0) begin : g_first
			assign p_in = ONE_Q14;
			assign q_in = base;
			assign s_in = shin;
		end else begin : g_next
			assign p_in = pc_s[k-1];
			assign q_in = qc_s[k-1];
			assign s_in = sc_s[k-1];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				pc_s[k] <= s_in[4+k] ? qmul(p_in, q_in) : p_in;
				qc_s[k] <= qmul(q_in, q_in);
				sc_s[k] <= s_in;
			end
		end
	end

	// fraction part: r1 = root(b), r2 = root(r1), ...
	logic [Q_W-1:0] rt [4];

	for (genvar j = 0; j < 4; j++) begin : g_root
		logic [ROOT_IW-1:0] rin;
		if (j == 0) begin : g_first
			assign rin = {1'b0, base, {FRAC{1'b0}}};
		end else begin : g_next
			assign rin = {1'b0, rt[j-1], {FRAC{1'b0}}};
		end
		plbp_sqrt #(.IW(ROOT_IW)) u_root (
			.clk  (clk),
			.en   (en),
			.x    (rin),
			.root (rt[j])
		);
	end

	// p waits for each root in turn, then takes it on its exponent bit
	logic [Q_W-1:0] pm_s [4];
	logic [3:0]     pb_s [4];

	for (genvar j = 0; j < 4; j++) begin : g_frac
		logic [Q_W+3:0] dl_in;
		logic [Q_W+3:0] dl_out;
		logic [Q_W-1:0] p_d;
		logic [3:0]     b_d;

		if (j == 0) begin : g_first
			assign dl_in = {sc_s[QSTEPS-1][3:0], pc_s[QSTEPS-1]};
			plbp_delay #(.W(Q_W+4), .N(ROOT_LAT-QSTEPS)) u_wait (
				.clk (clk), .en (en), .d (dl_in), .q (dl_out)
			);
		end else begin : g_next
			assign dl_in = {pb_s[j-1], pm_s[j-1]};
			plbp_delay #(.W(Q_W+4), .N(ROOT_LAT-1)) u_wait (
				.clk (clk), .en (en), .d (dl_in), .q (dl_out)
			);
		end

		assign p_d = dl_out[Q_W-1:0];
		assign b_d = dl_out[Q_W+3:Q_W];

		always_ff @(posedge clk) begin
			if (en) begin
				pm_s[j] <= b_d[3-j] ? qmul(p_d, rt[j]) : p_d;
				pb_s[j] <= b_d;
			end
		end
	end

	assign pw = pm_s[3];

endmodule

`default_nettype wire

@@ sv/point_light_blinn_phong_shade_core.sv @@
// point_light_blinn_phong_shade_core: top level of the blinn-phong point
// light shader; uses plbp_pkg, plbp_sqrt, plbp_div, plbp_pow and plbp_delay
//
//   channel  direction  handshake                    payload
//   sample   in         sample_valid/sample_ready    sample   (sample_t)
//   shade    out        shade_valid/shade_ready      shade    (shade_t)
//   config   in         cfg_we, no wait              cfg_addr, cfg_wdata
//
// one item enters per cycle while the output is not stalled; each item passes
// 138 register stages before its shade item is valid. the length is
// set by the two normalize passes (bit-serial root and divide stages)
// followed by the chained roots of the fractional exponent.
// a stalled output holds the whole pipe in place, so nothing is lost.
// reset clears the stage valid bits and the configuration registers.
`default_nettype none

module point_light_blinn_phong_shade_core
	import plbp_pkg::*;
(
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          sample_valid,
	output logic               sample_ready,
	input  wire sample_t       sample,
	output logic               shade_valid,
	input  wire logic          shade_ready,
	output shade_t             shade,
	input  wire logic          cfg_we,
	input  wire logic [2:0]    cfg_addr,
	input  wire logic [23:0]   cfg_wdata
);

	localparam int T_LEN1 = 3 + SQ1_LAT;
	localparam int T_Q1   = T_LEN1 + DIV_LAT;
	localparam int T_L    = T_Q1 + 1;
	localparam int T_LEN2 = T_L + 3 + SQ2_LAT;
	localparam int T_Q2   = T_LEN2 + DIV_LAT;
	localparam int T_H    = T_Q2 + 1;
	localparam int T_B    = T_H + 3;
	localparam int T_SI   = T_B + POW_LAT;
	localparam int LAT    = T_SI + 3;

	// configuration
	logic signed [15:0] lpos_q [3];
	logic [23:0]        dif_q;
	logic [23:0]        spc_q;
	logic [23:0]        amb_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lpos_q[0] <= '0;
			lpos_q[1] <= '0;
			lpos_q[2] <= '0;
			dif_q     <= '0;
			spc_q     <= '0;
			amb_q     <= '0;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_LIGHT_X:  lpos_q[0] <= cfg_wdata[15:0];
				REG_LIGHT_Y:  lpos_q[1] <= cfg_wdata[15:0];
				REG_LIGHT_Z:  lpos_q[2] <= cfg_wdata[15:0];
				REG_DIFFUSE:  dif_q     <= cfg_wdata;
				REG_SPECULAR: spc_q     <= cfg_wdata;
				REG_AMBIENT:  amb_q     <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// pipeline control: the whole pipe advances unless the output is stuck
	logic           adv;
	logic [LAT:1]   vld_q;

	assign adv          = !vld_q[LAT] || shade_ready;
	assign sample_ready = adv;
	assign shade_valid  = vld_q[LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[LAT-1:1], sample_valid};
		end
	end

	// stage 1: light and view vectors
	logic signed [15:0] pin [3];
	logic signed [15:0] ein [3];
	logic signed [15:0] nin [3];

	always_comb begin
		pin[0] = sample.surface_x;
		pin[1] = sample.surface_y;
		pin[2] = sample.surface_z;
		ein[0] = sample.eye_x;
		ein[1] = sample.eye_y;
		ein[2] = sample.eye_z;
		nin[0] = sample.normal_x;
		nin[1] = sample.normal_y;
		nin[2] = sample.normal_z;
	end

	logic signed [16:0] tl_s1 [3];
	logic signed [16:0] tv_s1 [3];
	logic [47:0]        n_s1;
	logic [8:0]         vis_s1;
	logic [11:0]        shin_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				tl_s1[i] <= {lpos_q[i][15], lpos_q[i]} - {pin[i][15], pin[i]};
				tv_s1[i] <= {ein[i][15], ein[i]} - {pin[i][15], pin[i]};
			end
			n_s1    <= {nin[0], nin[1], nin[2]};
			vis_s1  <= sample.visibility;
			shin_s1 <= sample.shininess;
		end
	end

	// stage 2: squares and magnitudes
	logic signed [33:0] prl [3];
	logic signed [33:0] prv [3];
	logic [16:0]        abl [3];
	logic [16:0]        abv [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			prl[i] = tl_s1[i] * tl_s1[i];
			prv[i] = tv_s1[i] * tv_s1[i];
			abl[i] = tl_s1[i][16] ? 17'(-tl_s1[i]) : 17'(tl_s1[i]);
			abv[i] = tv_s1[i][16] ? 17'(-tv_s1[i]) : 17'(tv_s1[i]);
		end
	end

	logic [31:0] sql_s2 [3];
	logic [31:0] sqv_s2 [3];
	logic [15:0] magl_s2 [3];
	logic [15:0] magv_s2 [3];
	logic [2:0]  sgnl_s2;
	logic [2:0]  sgnv_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				sql_s2[i]  <= prl[i][31:0];
				sqv_s2[i]  <= prv[i][31:0];
				magl_s2[i] <= abl[i][15:0];
				magv_s2[i] <= abv[i][15:0];
				sgnl_s2[i] <= tl_s1[i][16];
				sgnv_s2[i] <= tv_s1[i][16];
			end
		end
	end

	// stage 3: sums of squares
	logic [SQ1_IW-1:0] suml_s3;
	logic [SQ1_IW-1:0] sumv_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			suml_s3 <= SQ1_IW'(sql_s2[0]) + SQ1_IW'(sql_s2[1]) + SQ1_IW'(sql_s2[2]);
			sumv_s3 <= SQ1_IW'(sqv_s2[0]) + SQ1_IW'(sqv_s2[1]) + SQ1_IW'(sqv_s2[2]);
		end
	end

	// lengths of light and view vectors
	logic [SQ1_LAT-1:0] lenl;
	logic [SQ1_LAT-1:0] lenv;

	plbp_sqrt #(.IW(SQ1_IW)) u_len_l (.clk(clk), .en(adv), .x(suml_s3), .root(lenl));
	plbp_sqrt #(.IW(SQ1_IW)) u_len_v (.clk(clk), .en(adv), .x(sumv_s3), .root(lenv));

	logic [101:0] mag1_d;
	logic [101:0] mag1_q;

	assign mag1_d = {sgnl_s2, magl_s2[0], magl_s2[1], magl_s2[2],
		sgnv_s2, magv_s2[0], magv_s2[1], magv_s2[2]};

	plbp_delay #(.W(102), .N(SQ1_LAT+1)) u_mag1 (
		.clk(clk), .en(adv), .d(mag1_d), .q(mag1_q)
	);

	logic [15:0] magl_a [3];
	logic [15:0] magv_a [3];

	always_comb begin
		magl_a[0] = mag1_q[98:83];
		magl_a[1] = mag1_q[82:67];
		magl_a[2] = mag1_q[66:51];
		magv_a[0] = mag1_q[47:32];
		magv_a[1] = mag1_q[31:16];
		magv_a[2] = mag1_q[15:0];
	end

	// divide each magnitude by its length
	logic [DIV_QW-1:0] ql [3];
	logic [DIV_QW-1:0] qv [3];

	for (genvar g = 0; g < 3; g++) begin : g_div1
		plbp_div #(.NW(DIV_NW), .DW(DIV_DW), .QW(DIV_QW)) u_div_l (
			.clk(clk), .en(adv),
			.num({magl_a[g], {FRAC{1'b0}}}), .den(DIV_DW'(lenl)), .quo(ql[g])
		);
		plbp_div #(.NW(DIV_NW), .DW(DIV_DW), .QW(DIV_QW)) u_div_v (
			.clk(clk), .en(adv),
			.num({magv_a[g], {FRAC{1'b0}}}), .den(DIV_DW'(lenv)), .quo(qv[g])
		);
	end

	logic [7:0] sg1_d;
	logic [7:0] sg1_q;

	assign sg1_d = {lenl == '0, lenv == '0, mag1_q[101:99], mag1_q[50:48]};

	plbp_delay #(.W(8), .N(DIV_LAT)) u_sg1 (.clk(clk), .en(adv), .d(sg1_d), .q(sg1_q));

	// normal aligned with the unit vectors
	logic [47:0] n_l;

	plbp_delay #(.W(48), .N(T_L-2)) u_n1 (.clk(clk), .en(adv), .d(n_s1), .q(n_l));

	// stage 36: signed unit light and view vectors
	logic signed [15:0] l_s36 [3];
	logic signed [15:0] v_s36 [3];
	logic [47:0]        n_s36;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				if (sg1_q[7]) begin
					l_s36[i] <= '0;
				end else begin
					l_s36[i] <= sg1_q[3+i] ? -$signed({1'b0, ql[i]}) : $signed({1'b0, ql[i]});
				end
				if (sg1_q[6]) begin
					v_s36[i] <= '0;
				end else begin
					v_s36[i] <= sg1_q[i] ? -$signed({1'b0, qv[i]}) : $signed({1'b0, qv[i]});
				end
			end
			n_s36 <= n_l;
		end
	end

	logic signed [15:0] nv36 [3];

	always_comb begin
		nv36[0] = n_s36[47:32];
		nv36[1] = n_s36[31:16];
		nv36[2] = n_s36[15:0];
	end

	// stage 37: half vector sum and n.l products
	logic signed [16:0] th_s37  [3];
	logic signed [31:0] pdl_s37 [3];

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				th_s37[i]  <= 17'(l_s36[i]) + 17'(v_s36[i]);
				pdl_s37[i] <= nv36[i] * l_s36[i];
			end
		end
	end

	// stage 38: half vector squares and magnitudes, n.l sum
	logic signed [33:0] prh [3];
	logic [16:0]        abh [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			prh[i] = th_s37[i] * th_s37[i];
			abh[i] = th_s37[i][16] ? 17'(-th_s37[i]) : 17'(th_s37[i]);
		end
	end

	logic [31:0]        sqh_s38 [3];
	logic [15:0]        magh_s38 [3];
	logic [2:0]         sgnh_s38;
	logic signed [31:0] sdl_s38;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				sqh_s38[i]  <= prh[i][31:0];
				magh_s38[i] <= abh[i][15:0];
				sgnh_s38[i] <= th_s37[i][16];
			end
			sdl_s38 <= pdl_s37[0] + pdl_s37[1] + pdl_s37[2];
		end
	end

	// stage 39: half vector sum of squares, diffuse intensity
	logic [SQ2_IW-1:0] sumh_s39;
	logic [Q_W-1:0]    di_s39;

	always_ff @(posedge clk) begin
		if (adv) begin
			sumh_s39 <= sqh_s38[0] + sqh_s38[1] + sqh_s38[2];
			di_s39   <= clamp_q14(sdl_s38);
		end
	end

	logic [SQ2_LAT-1:0] lenh;

	plbp_sqrt #(.IW(SQ2_IW)) u_len_h (.clk(clk), .en(adv), .x(sumh_s39), .root(lenh));

	logic [50:0] mag2_d;
	logic [50:0] mag2_q;

	assign mag2_d = {sgnh_s38, magh_s38[0], magh_s38[1], magh_s38[2]};

	plbp_delay #(.W(51), .N(SQ2_LAT+1)) u_mag2 (
		.clk(clk), .en(adv), .d(mag2_d), .q(mag2_q)
	);

	logic [DIV_QW-1:0] qh [3];

	for (genvar g = 0; g < 3; g++) begin : g_div2
		plbp_div #(.NW(DIV_NW), .DW(DIV_DW), .QW(DIV_QW)) u_div_h (
			.clk(clk), .en(adv),
			.num({mag2_q[47-16*g -: 16], {FRAC{1'b0}}}), .den(DIV_DW'(lenh)),
			.quo(qh[g])
		);
	end

	logic [3:0] sg2_d;
	logic [3:0] sg2_q;

	assign sg2_d = {lenh == '0, mag2_q[50:48]};

	plbp_delay #(.W(4), .N(DIV_LAT)) u_sg2 (.clk(clk), .en(adv), .d(sg2_d), .q(sg2_q));

	logic [47:0] n_h;

	plbp_delay #(.W(48), .N(T_H-T_L-1)) u_n2 (.clk(clk), .en(adv), .d(n_s36), .q(n_h));

	// stage 71: signed unit half vector
	logic signed [15:0] h_s71 [3];
	logic [47:0]        n_s71;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				if (sg2_q[3]) begin
					h_s71[i] <= '0;
				end else begin
					h_s71[i] <= sg2_q[i] ? -$signed({1'b0, qh[i]}) : $signed({1'b0, qh[i]});
				end
			end
			n_s71 <= n_h;
		end
	end

	logic signed [15:0] nv71 [3];

	always_comb begin
		nv71[0] = n_s71[47:32];
		nv71[1] = n_s71[31:16];
		nv71[2] = n_s71[15:0];
	end

	// stages 72 to 74: h.n and the specular base
	logic signed [31:0] phn_s72 [3];
	logic signed [31:0] shn_s73;
	logic [Q_W-1:0]     b_s74;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				phn_s72[i] <= h_s71[i] * nv71[i];
			end
			shn_s73 <= phn_s72[0] + phn_s72[1] + phn_s72[2];
			b_s74   <= clamp_q14(shn_s73);
		end
	end

	logic [11:0] shin_b;

	plbp_delay #(.W(12), .N(T_B-1)) u_shin (.clk(clk), .en(adv), .d(shin_s1), .q(shin_b));

	logic [Q_W-1:0] si;

	plbp_pow u_pow (.clk(clk), .en(adv), .base(b_s74), .shin(shin_b), .pw(si));

	logic [Q_W-1:0] di_a;
	logic [8:0]     vis_a;

	plbp_delay #(.W(Q_W), .N(T_SI-(T_L+3))) u_di (
		.clk(clk), .en(adv), .d(di_s39), .q(di_a)
	);
	plbp_delay #(.W(9), .N(T_SI-1)) u_vis (.clk(clk), .en(adv), .d(vis_s1), .q(vis_a));

	// stage 136: intensity times visibility
	logic [23:0] ivd_s136;
	logic [23:0] ivs_s136;
	logic        vz_s136;

	always_ff @(posedge clk) begin
		if (adv) begin
			ivd_s136 <= {9'b0, di_a} * {15'b0, vis_a};
			ivs_s136 <= {9'b0, si} * {15'b0, vis_a};
			vz_s136  <= (vis_a == '0);
		end
	end

	// stage 137: per channel color products
	logic [31:0] cd_s137 [3];
	logic [31:0] cs_s137 [3];
	logic        vz_s137;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				cd_s137[i] <= 32'(dif_q[23-8*i -: 8]) * 32'(ivd_s136);
				cs_s137[i] <= 32'(spc_q[23-8*i -: 8]) * 32'(ivs_s136);
			end
			vz_s137 <= vz_s136;
		end
	end

	// stage 138: output item, all zero when not visible
	shade_t shade_s138;

	always_ff @(posedge clk) begin
		if (adv) begin
			if (vz_s137) begin
				shade_s138 <= '0;
			end else begin
				shade_s138.lit       <= 1'b1;
				shade_s138.diffuse_r <= chan_sat(cd_s137[0]);
				shade_s138.diffuse_g <= chan_sat(cd_s137[1]);
				shade_s138.diffuse_b <= chan_sat(cd_s137[2]);
				shade_s138.spec_r    <= chan_sat(cs_s137[0]);
				shade_s138.spec_g    <= chan_sat(cs_s137[1]);
				shade_s138.spec_b    <= chan_sat(cs_s137[2]);
				shade_s138.amb_r     <= amb_q[23:16];
				shade_s138.amb_g     <= amb_q[15:8];
				shade_s138.amb_b     <= amb_q[7:0];
			end
		end
	end

	assign shade = shade_s138;

endmodule

`default_nettype wire
